### hdl/track_gap_linear_fill_unit_macros.svh
// Assertion helpers for the gap fill unit.
`ifndef TRACK_GAP_LINEAR_FILL_UNIT_MACROS_SVH
`define TRACK_GAP_LINEAR_FILL_UNIT_MACROS_SVH

// Checked only while out of reset.
`define TGLF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define TGLF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/tglf_pkg.sv
`default_nettype none

package tglf_pkg;

    localparam int COORD_W = 16;
    localparam int TIME_W  = 31;
    // running quotient of a filled coordinate, signed
    localparam int QW      = 18;

    // sequencer steps
    localparam logic [2:0] PC_WAIT     = 3'd0;
    localparam logic [2:0] PC_CLASSIFY = 3'd1;
    localparam logic [2:0] PC_DIVIDE   = 3'd2;
    localparam logic [2:0] PC_FIX      = 3'd3;
    localparam logic [2:0] PC_FILL     = 3'd4;
    localparam logic [2:0] PC_SAMPLE   = 3'd5;

    // jump conditions
    localparam logic [2:0] COND_ALWAYS    = 3'd0;
    localparam logic [2:0] COND_ACCEPT    = 3'd1;
    localparam logic [2:0] COND_NOFILL    = 3'd2;
    localparam logic [2:0] COND_DIV_LAST  = 3'd3;
    localparam logic [2:0] COND_FILL_LAST = 3'd4;
    localparam logic [2:0] COND_SLOT_FREE = 3'd5;

    typedef struct packed {
        logic       in_ready;
        logic       div_load;
        logic       div_step;
        logic       div_fix;
        logic       fill;
        logic       emit;
        logic [2:0] cond;
        logic       hold;    // 1: stay when cond is false, 0: go to next step
        logic [2:0] target;
    } ctl_word_t;

    function automatic ctl_word_t ucode(input logic [2:0] pc);
        ctl_word_t w;
        w = '0;
        unique case (pc)
            PC_WAIT: begin
                w.in_ready = 1'b1;
                w.cond     = COND_ACCEPT;
                w.hold     = 1'b1;
                w.target   = PC_CLASSIFY;
            end
            PC_CLASSIFY: begin
                w.div_load = 1'b1;
                w.cond     = COND_NOFILL;
                w.hold     = 1'b0;
                w.target   = PC_SAMPLE;
            end
            PC_DIVIDE: begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_LAST;
                w.hold     = 1'b1;
                w.target   = PC_FIX;
            end
            PC_FIX: begin
                w.div_fix = 1'b1;
                w.cond    = COND_ALWAYS;
                w.hold    = 1'b1;
                w.target  = PC_FILL;
            end
            PC_FILL: begin
                w.fill   = 1'b1;
                w.cond   = COND_FILL_LAST;
                w.hold   = 1'b1;
                w.target = PC_SAMPLE;
            end
            PC_SAMPLE: begin
                w.emit   = 1'b1;
                w.cond   = COND_SLOT_FREE;
                w.hold   = 1'b1;
                w.target = PC_WAIT;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.hold   = 1'b1;
                w.target = PC_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hdl/track_gap_linear_fill_unit.sv
// A sample with nothing to fill is classified and emitted once its beat is taken.
// With a gap d in 2..MAX_GAP the filled results leave first, after the division,
// one result per cycle while m_tready is high, the sample itself last.
// A new sample is taken only after the last one has been emitted; the fill uses the
// 16-step serial divider (one bit per cycle, both axes at once).
// Reset clears the step counter, the output valid and the stored previous sample.
`default_nettype none

module track_gap_linear_fill_unit #(
    parameter int MAX_GAP = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // sample_time[30:0], pos_x[46:31], pos_y[62:47]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // out_time[30:0], out_x[46:31], out_y[62:47]
    output logic [1:0]       m_tuser,   // is_filled[0], gap_skipped[1]
    output logic             m_tlast
);

`include "track_gap_linear_fill_unit_macros.svh"

    localparam int GAP_W = $clog2(MAX_GAP + 1);
    localparam int CW    = tglf_pkg::COORD_W;
    localparam int TW    = tglf_pkg::TIME_W;
    localparam int QW    = tglf_pkg::QW;

    tglf_pkg::ctl_word_t ctl;

    logic [2:0]  pc_reg, pc_next;
    logic        jump;

    logic [TW-1:0]      cur_time_reg;
    logic [1:0][CW-1:0] cur_pos_reg;
    logic               have_prev_reg;
    logic [TW-1:0]      prev_time_reg;
    logic [1:0][CW-1:0] prev_pos_reg;

    logic               skip_reg;
    logic [GAP_W-1:0]   gap_reg;
    logic [GAP_W-1:0]   t_reg;
    logic [3:0]         div_cnt_reg;
    logic [1:0]         neg_reg;
    logic [1:0][CW-1:0] dvd_reg;
    logic [1:0][GAP_W-1:0] rem_reg;
    logic [1:0][QW-1:0]    step_a_reg;
    logic [1:0][GAP_W-1:0] step_b_reg;
    logic [1:0][QW-1:0]    acc_q_reg;
    logic [1:0][GAP_W-1:0] acc_r_reg;

    logic               m_valid_reg;
    logic [TW-1:0]      m_time_reg;
    logic [1:0][CW-1:0] m_pos_reg;
    logic               m_filled_reg, m_last_reg, m_skip_reg;

    logic               slot_free;
    logic signed [31:0] gap_diff;
    logic               fill_now, skip_now;
    logic [1:0]         delta_neg;
    logic [1:0][CW-1:0] delta_mag;
    logic [1:0][CW-1:0] dvd_next;
    logic [1:0][GAP_W-1:0] rem_next;
    logic [1:0][QW-1:0]    fix_a;
    logic [1:0][GAP_W-1:0] fix_b;
    logic [1:0][QW-1:0]    fill_q;
    logic [1:0][GAP_W-1:0] fill_r;
    logic [1:0][CW-1:0]    fill_pos;
    logic [GAP_W-1:0]      t_inc;
    logic                  fill_last;

    assign ctl       = tglf_pkg::ucode(pc_reg);
    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = ctl.in_ready;
    assign t_inc     = t_reg + GAP_W'(1);
    assign fill_last = ({1'b0, t_reg} + (GAP_W + 1)'(2)) == {1'b0, gap_reg};

    // gap classification against the stored sample
    always_comb begin
        gap_diff = $signed({1'b0, cur_time_reg}) - $signed({1'b0, prev_time_reg});
        fill_now = have_prev_reg && (gap_diff >= 32'sd2) && (gap_diff <= 32'(MAX_GAP));
        skip_now = have_prev_reg && (gap_diff > 32'(MAX_GAP));
    end

    // per-axis datapath: divider step, sign fix-up, fill accumulator
    always_comb begin
        logic signed [CW:0]   delta;
        logic [GAP_W:0]       trial;
        logic                 ge;
        logic [GAP_W:0]       rsum;
        logic                 carry;
        logic [QW-1:0]        qn;
        logic [QW-1:0]        qt;
        logic [QW-1:0]        qmag;
        for (int i = 0; i < 2; i++) begin
            delta = $signed({cur_pos_reg[i][CW-1], cur_pos_reg[i]})
                  - $signed({prev_pos_reg[i][CW-1], prev_pos_reg[i]});
            delta_neg[i] = delta[CW];
            delta_mag[i] = delta[CW] ? CW'(-delta) : delta[CW-1:0];

            trial       = {rem_reg[i], dvd_reg[i][CW-1]};
            ge          = trial >= {1'b0, gap_reg};
            rem_next[i] = ge ? GAP_W'(trial - {1'b0, gap_reg}) : trial[GAP_W-1:0];
            dvd_next[i] = {dvd_reg[i][CW-2:0], ge};

            // floor division of delta by the gap: delta = a*d + b, 0 <= b < d
            qmag = {{(QW - CW){1'b0}}, dvd_reg[i]};
            if (neg_reg[i] && rem_reg[i] != '0) begin
                fix_a[i] = -(qmag + QW'(1));
                fix_b[i] = gap_reg - rem_reg[i];
            end else if (neg_reg[i]) begin
                fix_a[i] = -qmag;
                fix_b[i] = '0;
            end else begin
                fix_a[i] = qmag;
                fix_b[i] = rem_reg[i];
            end

            rsum      = {1'b0, acc_r_reg[i]} + {1'b0, step_b_reg[i]};
            carry     = rsum >= {1'b0, gap_reg};
            fill_r[i] = carry ? GAP_W'(rsum - {1'b0, gap_reg}) : rsum[GAP_W-1:0];
            qn        = acc_q_reg[i] + step_a_reg[i] + QW'(carry);
            fill_q[i] = qn;
            // round the floor quotient toward zero
            qt        = qn + QW'(qn[QW-1] && fill_r[i] != '0);
            fill_pos[i] = prev_pos_reg[i] + qt[CW-1:0];
        end
    end

    always_comb begin
        unique case (ctl.cond)
            tglf_pkg::COND_ALWAYS:    jump = 1'b1;
            tglf_pkg::COND_ACCEPT:    jump = s_tvalid;
            tglf_pkg::COND_NOFILL:    jump = !fill_now;
            tglf_pkg::COND_DIV_LAST:  jump = div_cnt_reg == '0;
            tglf_pkg::COND_FILL_LAST: jump = slot_free && fill_last;
            tglf_pkg::COND_SLOT_FREE: jump = slot_free;
            default:                  jump = 1'b1;
        endcase
        if (jump) begin
            pc_next = ctl.target;
        end else if (ctl.hold) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= tglf_pkg::PC_WAIT;
            m_valid_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_time_reg <= '0;
            prev_pos_reg  <= '0;
        end else begin
            pc_reg <= pc_next;
            if (ctl.emit && slot_free) begin
                m_valid_reg   <= 1'b1;
                have_prev_reg <= 1'b1;
                prev_time_reg <= cur_time_reg;
                prev_pos_reg  <= cur_pos_reg;
            end else if (ctl.fill && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.in_ready && s_tvalid) begin
            cur_time_reg   <= s_tdata[TW-1:0];
            cur_pos_reg[0] <= s_tdata[TW+CW-1:TW];
            cur_pos_reg[1] <= s_tdata[TW+2*CW-1:TW+CW];
        end
        if (ctl.div_load) begin
            skip_reg    <= skip_now;
            gap_reg     <= gap_diff[GAP_W-1:0];
            div_cnt_reg <= 4'(CW - 1);
            neg_reg     <= delta_neg;
            dvd_reg     <= delta_mag;
            rem_reg     <= '0;
        end
        if (ctl.div_step) begin
            div_cnt_reg <= div_cnt_reg - 4'd1;
            dvd_reg     <= dvd_next;
            rem_reg     <= rem_next;
        end
        if (ctl.div_fix) begin
            step_a_reg <= fix_a;
            step_b_reg <= fix_b;
            acc_q_reg  <= '0;
            t_reg      <= '0;
            // numerator starts at half the gap
            for (int i = 0; i < 2; i++) begin
                acc_r_reg[i] <= gap_reg >> 1;
            end
        end
        if (ctl.fill && slot_free) begin
            acc_q_reg    <= fill_q;
            acc_r_reg    <= fill_r;
            t_reg        <= t_inc;
            m_time_reg   <= prev_time_reg + TW'(t_inc);
            m_pos_reg    <= fill_pos;
            m_filled_reg <= 1'b1;
            m_last_reg   <= 1'b0;
            m_skip_reg   <= 1'b0;
        end
        if (ctl.emit && slot_free) begin
            m_time_reg   <= cur_time_reg;
            m_pos_reg    <= cur_pos_reg;
            m_filled_reg <= 1'b0;
            m_last_reg   <= 1'b1;
            m_skip_reg   <= skip_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_pos_reg[1], m_pos_reg[0], m_time_reg};
    assign m_tuser  = {m_skip_reg, m_filled_reg};
    assign m_tlast  = m_last_reg;

    `TGLF_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "output valid after reset")
    `TGLF_ASSERT(a_filled_not_last, m_tvalid && m_tuser[0] |-> !m_tlast && !m_tuser[1], "filled beat marked last or skipped")
    `TGLF_ASSERT(a_accept_classify, s_tvalid && s_tready |=> pc_reg == tglf_pkg::PC_CLASSIFY, "accepted beat not classified")
    `TGLF_ASSERT(a_fill_rem_range, pc_reg == tglf_pkg::PC_FILL |-> acc_r_reg[0] < gap_reg && acc_r_reg[1] < gap_reg, "fill remainder out of range")

endmodule

`default_nettype wire
